// ===== rtl/cdtt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdtt_pkg: shared types, constants and arithmetic helpers
// Fixed-point constants, coefficient tables, sequencer states and rounding.
// ----------------------------------------------------------------------------
package cdtt_pkg;

  localparam int MUL_W    = 34;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int COEF_LEN = 64;

  typedef logic signed [MUL_W-1:0]  mul_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam longint SIN_C1 = 1686629713;
  localparam longint SIN_C3 = 693598669;
  localparam longint SIN_C5 = 85569306;
  localparam longint SIN_C7 = 5026995;
  localparam longint SIN_C9 = 172272;
  localparam longint INV_TWO_PI_Q32 = 683565276;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [15:0] loop_gain;
  } cfg_t;

  typedef enum logic [0:0] {
    REG_PHASE_STEP,
    REG_LOOP_GAIN
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SIN_U,
    ST_SIN_SQ,
    ST_SIN_U2,
    ST_SIN_MUL,
    ST_SIN_ADD,
    ST_SIN_FMUL,
    ST_SIN_FIN,
    ST_MIX_MUL,
    ST_MIX,
    ST_WRITE,
    ST_FIR_RD,
    ST_FIR_MI,
    ST_FIR_MQ,
    ST_FIR_LAST,
    ST_FIR_END,
    ST_LOOP_M1,
    ST_LOOP_M2,
    ST_LOOP_M3,
    ST_LOOP_UPD,
    ST_BQ_M0,
    ST_BQ_M1,
    ST_BQ_M2,
    ST_BQ_M3,
    ST_BQ_END,
    ST_SQ_M,
    ST_SQ,
    ST_OUT
  } state_t;

  localparam int PULSE_MICRO [COEF_LEN] = '{
    0, 163, 0, -576, -1624, -3164, -5162, -7522,
    -10081, -12608, -14806, -16326, -16777, -15752, -12850, -7702,
    0, 10474, 23826, 40029, 58914, 80159, 103297, 127730,
    152748, 177557, 201320, 223195, 242375, 258132, 269854, 277080,
    279521, 277080, 269854, 258132, 242375, 223195, 201320, 177557,
    152748, 127730, 103297, 80159, 58914, 40029, 23826, 10474,
    0, -7702, -12850, -15752, -16777, -16326, -14806, -12608,
    -10081, -7522, -5162, -3164, -1624, -576, 0, 163
  };

  typedef logic signed [31:0] coef_tab_t [COEF_LEN];

  function automatic longint micro_to_q30(input longint m);
    return (m * 64'sd1073741824 + (m >= 0 ? 64'sd500000 : -64'sd500000)) / 64'sd1000000;
  endfunction

  function automatic longint nano_to_q30(input longint n);
    return (n * 64'sd1073741824 + (n >= 0 ? 64'sd500000000 : -64'sd500000000))
           / 64'sd1000000000;
  endfunction

  function automatic coef_tab_t build_pulse();
    coef_tab_t t;
    for (int k = 0; k < COEF_LEN; k++) begin
      t[k] = 32'(micro_to_q30(longint'(PULSE_MICRO[k])));
    end
    return t;
  endfunction

  localparam coef_tab_t PULSE_Q30 = build_pulse();

  localparam logic signed [31:0] BPF1_B0 = 32'(nano_to_q30(12699218));
  localparam logic signed [31:0] BPF1_A1 = 32'(nano_to_q30(-1936701629));
  localparam logic signed [31:0] BPF1_A2 = 32'(nano_to_q30(974601564));
  localparam logic signed [31:0] BPF2_B0 = 32'(nano_to_q30(25080988));
  localparam logic signed [31:0] BPF2_A1 = 32'(nano_to_q30(-1801569787));
  localparam logic signed [31:0] BPF2_A2 = 32'(nano_to_q30(949838024));

  // Taps beyond the table weigh nothing
  function automatic logic signed [31:0] tap_coef(input logic [7:0] k);
    if (k < 8'(COEF_LEN)) begin
      return PULSE_Q30[k[5:0]];
    end
    return 32'sd0;
  endfunction

  // Odd polynomial terms, highest first after C9
  function automatic mul_t sin_add(input logic [1:0] i);
    case (i)
      2'd0:    return -mul_t'(SIN_C7);
      2'd1:    return mul_t'(SIN_C5);
      2'd2:    return -mul_t'(SIN_C3);
      default: return mul_t'(SIN_C1);
    endcase
  endfunction

  // Shift right, ties toward plus infinity
  function automatic prod_t rnd_shift(input prod_t v, input int unsigned s);
    prod_t h;
    prod_t t;
    h = PROD_W'(1) << (s - 1);
    t = v + h;
    return t >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(input prod_t v);
    if (v > 68'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -68'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input prod_t v);
    if (v > 68'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (v < -68'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cdtt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdtt_if: stream channels
// Valid/ready channels for received samples and for demodulated results.
// ----------------------------------------------------------------------------
interface cdtt_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] rx_sample;

  modport source (output valid, output rx_sample, input ready);
  modport sink   (input valid, input rx_sample, output ready);
endinterface

interface cdtt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] timing_tone;
  logic signed [15:0] baseband_i;
  logic signed [15:0] baseband_q;

  modport source (output valid, output timing_tone, output baseband_i,
                  output baseband_q, input ready);
  modport sink   (input valid, input timing_tone, input baseband_i,
                  input baseband_q, output ready);
endinterface
`default_nettype wire

// ===== rtl/cdtt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdtt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cdtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/cdtt_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdtt_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module cdtt_mul (
  input  wire logic               clk,
  input  wire cdtt_pkg::mul_t     a,
  input  wire cdtt_pkg::mul_t     b,
  output cdtt_pkg::prod_t         prod
);
  import cdtt_pkg::*;

  always_ff @(posedge clk) begin
    prod <= prod_t'(a) * prod_t'(b);
  end
endmodule
`default_nettype wire

// ===== rtl/cdtt_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdtt_regs: configuration registers
// APB-style write and read of the phase step and the loop gain.
// ----------------------------------------------------------------------------
module cdtt_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  output cdtt_pkg::cfg_t    cfg
);
  import cdtt_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = 32'd0;
    case (idx)
      REG_PHASE_STEP: begin
        prdata = cfg_r.phase_step;
        if (wr_en) begin
          cfg_nxt.phase_step = pwdata;
        end
      end
      REG_LOOP_GAIN: begin
        prdata = {16'd0, cfg_r.loop_gain};
        if (wr_en) begin
          cfg_nxt.loop_gain = pwdata[15:0];
        end
      end
      default: begin
        prdata = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step <= 32'h4000_0000;
      cfg_r.loop_gain  <= 16'd655;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/costas_demod_timing_tone_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// costas_demod_timing_tone_unit: Costas demodulator with timing tone
// Carrier mixing, pulse-shaping FIR, Costas loop and squaring timing tone.
// ----------------------------------------------------------------------------
// One sample is taken at a time. Its result becomes valid when the sample's
// work ends, and in_ch.ready is low meanwhile. The next sample can be taken
// once the result is in the output register. The FIR sweep, two products
// per tap, makes up most of the work; before it come the two polynomial
// sines, after it the loop update, the two biquads and the square. A result
// that cannot leave because the output register is still full holds the block
// in its last state until out_ch.ready frees it. Every product of the
// sample's work, the two polynomial sines, the mixer, two per FIR tap, the
// loop correction, both biquads and the square, goes through one shared
// 34x34 multiplier, and the FIR taps are read one per product pair from a
// single RAM holding I and Q. The delay lines read as zero until filled, so
// the block needs no clearing pass after reset. A finished result waits in
// the output register while the next sample is taken.
// ----------------------------------------------------------------------------
module costas_demod_timing_tone_unit #(
  parameter int FIR_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cdtt_in_if.sink          in_ch,
  cdtt_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import cdtt_pkg::*;

  localparam int AW = $clog2(FIR_TAPS);
  localparam int FW = $clog2(FIR_TAPS + 1);

  cfg_t   cfg;
  mul_t   mul_a;
  mul_t   mul_b;
  prod_t  prod;

  // control state
  state_t             state_r, state_nxt;
  logic               sel_r, sel_nxt;
  logic               bsel_r, bsel_nxt;
  logic [1:0]         pcnt_r, pcnt_nxt;
  logic [AW-1:0]      k_r, k_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [31:0]        phase_r, phase_nxt;
  logic signed [31:0] xh_r [2][2];
  logic signed [31:0] yh_r [2][2];
  logic signed [31:0] xh_nxt [2][2];
  logic signed [31:0] yh_nxt [2][2];
  logic               out_valid_r, out_valid_nxt;

  // payload
  logic signed [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic                          neg_r, neg_nxt;
  logic [30:0]                   u_r, u_nxt;
  mul_t                          u2_r, u2_nxt;
  mul_t                          sacc_r, sacc_nxt;
  logic signed [31:0]            sin_r, sin_nxt;
  logic signed [15:0]            mix_i_r, mix_i_nxt;
  logic signed [15:0]            mix_q_r, mix_q_nxt;
  prod_t                         acc_i_r, acc_i_nxt;
  prod_t                         acc_q_r, acc_q_nxt;
  logic signed [15:0]            bi_r, bi_nxt;
  logic signed [15:0]            bq_r, bq_nxt;
  logic signed [31:0]            x0_r, x0_nxt;
  logic signed [31:0]            y1_r, y1_nxt;
  logic signed [15:0]            tone_r, tone_nxt;
  logic signed [15:0]            o_tone_r, o_tone_nxt;
  logic signed [15:0]            o_bi_r, o_bi_nxt;
  logic signed [15:0]            o_bq_r, o_bq_nxt;

  // RAM signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [AW-1:0]     rd_idx;
  logic [31:0]       ram_rdata;
  logic              tap_ok;
  logic signed [15:0] dat_i, dat_q;
  logic signed [31:0] coef;

  // datapath temporaries
  logic [31:0]        ph;
  logic [31:0]        rr;
  prod_t              rsv;
  prod_t              sv;
  logic signed [31:0] b0, a1, a2;
  logic signed [32:0] xd;
  logic signed [31:0] yq;

  cdtt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cdtt_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  cdtt_ram #(
    .WIDTH (32),
    .DEPTH (FIR_TAPS)
  ) u_dly (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({mix_i_r, mix_q_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.timing_tone = o_tone_r;
  assign out_ch.baseband_i  = o_bi_r;
  assign out_ch.baseband_q  = o_bq_r;

  // Tap k sits k entries behind the write pointer, modulo the line length
  always_comb begin
    if (wp_r >= rd_idx) begin
      ram_raddr = wp_r - rd_idx;
    end else begin
      ram_raddr = AW'({1'b0, wp_r} + (AW + 1)'(FIR_TAPS) - {1'b0, rd_idx});
    end
  end

  assign tap_ok = (FW'(k_r) < fill_r);
  assign dat_i  = tap_ok ? $signed(ram_rdata[31:16]) : 16'sd0;
  assign dat_q  = tap_ok ? $signed(ram_rdata[15:0]) : 16'sd0;
  assign coef   = tap_coef(8'(k_r));

  always_comb begin
    if (bsel_r) begin
      b0 = BPF2_B0;
      a1 = BPF2_A1;
      a2 = BPF2_A2;
    end else begin
      b0 = BPF1_B0;
      a1 = BPF1_A1;
      a2 = BPF1_A2;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    bsel_nxt      = bsel_r;
    pcnt_nxt      = pcnt_r;
    k_nxt         = k_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    phase_nxt     = phase_r;
    xh_nxt        = xh_r;
    yh_nxt        = yh_r;
    out_valid_nxt = out_valid_r;
    smp_nxt       = smp_r;
    neg_nxt       = neg_r;
    u_nxt         = u_r;
    u2_nxt        = u2_r;
    sacc_nxt      = sacc_r;
    sin_nxt       = sin_r;
    mix_i_nxt     = mix_i_r;
    mix_q_nxt     = mix_q_r;
    acc_i_nxt     = acc_i_r;
    acc_q_nxt     = acc_q_r;
    bi_nxt        = bi_r;
    bq_nxt        = bq_r;
    x0_nxt        = x0_r;
    y1_nxt        = y1_r;
    tone_nxt      = tone_r;
    o_tone_nxt    = o_tone_r;
    o_bi_nxt      = o_bi_r;
    o_bq_nxt      = o_bq_r;
    mul_a         = '0;
    mul_b         = '0;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    rd_idx        = k_r;
    ph            = phase_r + (sel_r ? 32'd0 : QUARTER_TURN);
    rr            = {1'b0, ph[30:0]};
    rsv           = '0;
    sv            = '0;
    xd            = {x0_r[31], x0_r} - {xh_r[bsel_r][1][31], xh_r[bsel_r][1]};
    yq            = '0;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          smp_nxt   = in_ch.rx_sample;
          sel_nxt   = 1'b0;
          state_nxt = ST_SIN_U;
        end
      end
      // fold the phase into one quarter turn
      ST_SIN_U: begin
        if (rr > QUARTER_TURN) begin
          rr = HALF_TURN - rr;
        end
        neg_nxt   = ph[31];
        u_nxt     = rr[30:0];
        state_nxt = ST_SIN_SQ;
      end
      ST_SIN_SQ: begin
        mul_a     = mul_t'({1'b0, u_r});
        mul_b     = mul_t'({1'b0, u_r});
        state_nxt = ST_SIN_U2;
      end
      ST_SIN_U2: begin
        rsv       = rnd_shift(prod, 30);
        u2_nxt    = $signed(rsv[MUL_W-1:0]);
        sacc_nxt  = mul_t'(SIN_C9);
        pcnt_nxt  = 2'd0;
        state_nxt = ST_SIN_MUL;
      end
      ST_SIN_MUL: begin
        mul_a     = sacc_r;
        mul_b     = u2_r;
        state_nxt = ST_SIN_ADD;
      end
      ST_SIN_ADD: begin
        rsv      = rnd_shift(prod, 30);
        sacc_nxt = $signed(rsv[MUL_W-1:0]) + sin_add(pcnt_r);
        pcnt_nxt = pcnt_r + 2'd1;
        if (pcnt_r == 2'd3) begin
          state_nxt = ST_SIN_FMUL;
        end else begin
          state_nxt = ST_SIN_MUL;
        end
      end
      ST_SIN_FMUL: begin
        mul_a     = sacc_r;
        mul_b     = mul_t'({1'b0, u_r});
        state_nxt = ST_SIN_FIN;
      end
      // clamp to [0, 1] and restore the sign of the half turn
      ST_SIN_FIN: begin
        sv = rnd_shift(prod, 30);
        if (sv < 68'sd0) begin
          sv = '0;
        end else if (sv > 68'sd1073741824) begin
          sv = 68'sd1073741824;
        end
        sin_nxt   = neg_r ? -sv[31:0] : sv[31:0];
        state_nxt = ST_MIX_MUL;
      end
      ST_MIX_MUL: begin
        mul_a     = mul_t'(smp_r);
        mul_b     = mul_t'(sin_r);
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        if (!sel_r) begin
          mix_i_nxt = sat16(rnd_shift(prod, SAMPLE_BITS + 14));
          sel_nxt   = 1'b1;
          state_nxt = ST_SIN_U;
        end else begin
          mix_q_nxt = sat16(rnd_shift(prod, SAMPLE_BITS + 14));
          state_nxt = ST_WRITE;
        end
      end
      // push the newest mixer pair into the delay line
      ST_WRITE: begin
        wp_nxt    = (wp_r == AW'(FIR_TAPS - 1)) ? '0 : wp_r + 1'b1;
        ram_we    = 1'b1;
        ram_waddr = wp_nxt;
        if (fill_r != FW'(FIR_TAPS)) begin
          fill_nxt = fill_r + 1'b1;
        end
        k_nxt     = '0;
        acc_i_nxt = '0;
        acc_q_nxt = '0;
        state_nxt = ST_FIR_RD;
      end
      ST_FIR_RD: begin
        rd_idx    = k_r;
        state_nxt = ST_FIR_MI;
      end
      ST_FIR_MI: begin
        if (k_r != '0) begin
          acc_q_nxt = acc_q_r + prod;
        end
        mul_a     = mul_t'(dat_i);
        mul_b     = mul_t'(coef);
        state_nxt = ST_FIR_MQ;
      end
      // fetch the next tap while the Q product is formed
      ST_FIR_MQ: begin
        acc_i_nxt = acc_i_r + prod;
        mul_a     = mul_t'(dat_q);
        mul_b     = mul_t'(coef);
        rd_idx    = k_r + 1'b1;
        k_nxt     = k_r + 1'b1;
        if (k_r == AW'(FIR_TAPS - 1)) begin
          state_nxt = ST_FIR_LAST;
        end else begin
          state_nxt = ST_FIR_MI;
        end
      end
      ST_FIR_LAST: begin
        acc_q_nxt = acc_q_r + prod;
        state_nxt = ST_FIR_END;
      end
      ST_FIR_END: begin
        bi_nxt    = sat16(rnd_shift(acc_i_r, 30));
        bq_nxt    = sat16(rnd_shift(acc_q_r, 30));
        state_nxt = ST_LOOP_M1;
      end
      ST_LOOP_M1: begin
        mul_a     = mul_t'(bi_r);
        mul_b     = mul_t'(bq_r);
        state_nxt = ST_LOOP_M2;
      end
      ST_LOOP_M2: begin
        mul_a     = $signed(prod[MUL_W-1:0]);
        mul_b     = mul_t'({1'b0, cfg.loop_gain});
        state_nxt = ST_LOOP_M3;
      end
      ST_LOOP_M3: begin
        rsv       = rnd_shift(prod, 16);
        mul_a     = $signed(rsv[MUL_W-1:0]);
        mul_b     = mul_t'(INV_TWO_PI_Q32);
        state_nxt = ST_LOOP_UPD;
      end
      // advance the carrier, wrapping modulo one turn
      ST_LOOP_UPD: begin
        rsv       = rnd_shift(prod, 30);
        phase_nxt = phase_r + cfg.phase_step - rsv[31:0];
        x0_nxt    = {{7{bi_r[15]}}, bi_r, 9'd0};
        bsel_nxt  = 1'b0;
        state_nxt = ST_BQ_M0;
      end
      ST_BQ_M0: begin
        mul_a     = mul_t'(xd);
        mul_b     = mul_t'(b0);
        state_nxt = ST_BQ_M1;
      end
      ST_BQ_M1: begin
        acc_i_nxt = prod;
        mul_a     = mul_t'(yh_r[bsel_r][0]);
        mul_b     = mul_t'(a1);
        state_nxt = ST_BQ_M2;
      end
      ST_BQ_M2: begin
        acc_i_nxt = acc_i_r - prod;
        mul_a     = mul_t'(yh_r[bsel_r][1]);
        mul_b     = mul_t'(a2);
        state_nxt = ST_BQ_M3;
      end
      ST_BQ_M3: begin
        acc_i_nxt = acc_i_r - prod;
        state_nxt = ST_BQ_END;
      end
      ST_BQ_END: begin
        yq                    = sat32(rnd_shift(acc_i_r, 30));
        xh_nxt[bsel_r][1]     = xh_r[bsel_r][0];
        xh_nxt[bsel_r][0]     = x0_r;
        yh_nxt[bsel_r][1]     = yh_r[bsel_r][0];
        yh_nxt[bsel_r][0]     = yq;
        if (!bsel_r) begin
          y1_nxt    = yq;
          state_nxt = ST_SQ_M;
        end else begin
          tone_nxt  = sat16(rnd_shift(prod_t'(yq), 8));
          state_nxt = ST_OUT;
        end
      end
      ST_SQ_M: begin
        mul_a     = mul_t'(y1_r);
        mul_b     = mul_t'(y1_r);
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        x0_nxt    = sat32(rnd_shift(prod, 24));
        bsel_nxt  = 1'b1;
        state_nxt = ST_BQ_M0;
      end
      // hold until the output register is free
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          o_tone_nxt    = tone_r;
          o_bi_nxt      = bi_r;
          o_bq_nxt      = bq_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= 1'b0;
      bsel_r      <= 1'b0;
      pcnt_r      <= '0;
      k_r         <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      phase_r     <= '0;
      xh_r        <= '{'{32'sd0, 32'sd0}, '{32'sd0, 32'sd0}};
      yh_r        <= '{'{32'sd0, 32'sd0}, '{32'sd0, 32'sd0}};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      bsel_r      <= bsel_nxt;
      pcnt_r      <= pcnt_nxt;
      k_r         <= k_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      phase_r     <= phase_nxt;
      xh_r        <= xh_nxt;
      yh_r        <= yh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r    <= smp_nxt;
    neg_r    <= neg_nxt;
    u_r      <= u_nxt;
    u2_r     <= u2_nxt;
    sacc_r   <= sacc_nxt;
    sin_r    <= sin_nxt;
    mix_i_r  <= mix_i_nxt;
    mix_q_r  <= mix_q_nxt;
    acc_i_r  <= acc_i_nxt;
    acc_q_r  <= acc_q_nxt;
    bi_r     <= bi_nxt;
    bq_r     <= bq_nxt;
    x0_r     <= x0_nxt;
    y1_r     <= y1_nxt;
    tone_r   <= tone_nxt;
    o_tone_r <= o_tone_nxt;
    o_bi_r   <= o_bi_nxt;
    o_bq_r   <= o_bq_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(FIR_TAPS))
    else $error("delay line fill count beyond its length");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second sample taken while one is at work");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && out_valid_r && !out_ch.ready |=> state_r == ST_OUT)
    else $error("result dropped while output register was full");

  a_tap_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIR_LAST |-> $past(k_r) == AW'(FIR_TAPS - 1))
    else $error("FIR sweep ended early");
endmodule
`default_nettype wire
